// ===== rtl/core/cbc_pkg.sv =====
// Shared constants and types for the capsule brush coverage block.
// No dependencies; imported by every module of the block.
package cbc_pkg;

    // Fraction bits of the projection parameter along the segment.
    localparam int T_BITS = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_HARDNESS = 3'd5;

    // Which point of the segment is nearest to the pixel centre.
    typedef logic [1:0] seg_mode_t;
    localparam seg_mode_t MODE_START = 2'd0;
    localparam seg_mode_t MODE_END   = 2'd1;
    localparam seg_mode_t MODE_MID   = 2'd2;

endpackage

// ===== rtl/core/cbc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Needs numerator below denominator; carries a side payload. Uses cbc_pkg.
module cbc_div_pipe #(
    parameter int DEN_W  = 20,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);
    import cbc_pkg::*;

    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic              valid_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quot_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [DEN_W:0]    shifted;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign rem_in   = in_num;
            assign den_in   = in_den;
            assign quot_in  = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quot_in  = quot_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign ge      = shifted >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? DEN_W'(shifted - {1'b0, den_in}) : DEN_W'(shifted);
            den_reg[i]  <= den_in;
            quot_reg[i] <= {quot_in[Q_W-2:0], ge};
            side_reg[i] <= side_in;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== rtl/core/cbc_sqrt_pipe.sv =====
// Pipelined integer square root (floor), one root bit per register stage.
// Carries a side payload alongside; uses cbc_pkg.
module cbc_sqrt_pipe #(
    parameter int RAD_W  = 54,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);
    import cbc_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int N_W    = RAD_W + 1;

    logic [N_W-1:0]    n_reg     [ROOT_W];
    logic [N_W-1:0]    res_reg   [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (ROOT_W - 1 - i));
        logic [N_W-1:0]    n_in;
        logic [N_W-1:0]    res_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [N_W-1:0]    trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign n_in     = {1'b0, in_rad};
            assign res_in   = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign n_in     = n_reg[i-1];
            assign res_in   = res_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign trial = res_in + BIT;
        assign ge    = n_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[i]    <= ge ? n_in - trial : n_in;
            res_reg[i]  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
            side_reg[i] <= side_in;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== rtl/core/cbc_smooth.sv =====
// Three-stage quintic smootherstep u^3 (6u^2 - 15u + 10) in Q0.C fixed point.
// Carries a side payload alongside; uses cbc_pkg.
module cbc_smooth #(
    parameter int COVERAGE_BITS = 16,
    parameter int SIDE_W        = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [COVERAGE_BITS-1:0] in_u,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [COVERAGE_BITS:0] out_s,
    output logic [SIDE_W-1:0]      out_side
);
    import cbc_pkg::*;

    localparam int C    = COVERAGE_BITS;
    localparam int PL_W = C + 4;
    localparam int S_W  = 2 * C + 5;
    localparam logic [2*C-1:0]  HALF_M = (2*C)'(1) << (C - 1);
    localparam logic [S_W-1:0]  HALF_S = S_W'(1) << (C - 1);
    localparam logic [PL_W-1:0] TEN    = PL_W'(10) << C;
    localparam logic [C:0]      ONE    = (C+1)'(1) << C;

    logic [2*C-1:0]  u2_full;
    logic [2*C-1:0]  u3_full;
    logic [PL_W-1:0] pos;
    logic [PL_W-1:0] neg;
    logic [S_W-1:0]  s_full;
    logic [PL_W-1:0] s_short;

    logic [C-1:0]      m1_u2_reg;
    logic [C-1:0]      m1_u_reg;
    logic [C-1:0]      m2_u3_reg;
    logic [PL_W-1:0]   m2_poly_reg;
    logic [C:0]        m3_s_reg;
    logic [SIDE_W-1:0] m1_side_reg;
    logic [SIDE_W-1:0] m2_side_reg;
    logic [SIDE_W-1:0] m3_side_reg;
    logic              m1_valid_reg;
    logic              m2_valid_reg;
    logic              m3_valid_reg;

    assign u2_full = in_u * in_u + HALF_M;
    assign u3_full = m1_u2_reg * m1_u_reg + HALF_M;
    assign pos     = PL_W'(6) * PL_W'(m1_u2_reg) + TEN;
    assign neg     = PL_W'(15) * PL_W'(m1_u_reg);
    assign s_full  = S_W'(m2_u3_reg) * S_W'(m2_poly_reg) + HALF_S;
    assign s_short = s_full[C+PL_W-1:C];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_u2_reg   <= u2_full[2*C-1:C];
        m1_u_reg    <= in_u;
        m1_side_reg <= in_side;
        m2_u3_reg   <= u3_full[2*C-1:C];
        m2_poly_reg <= (pos > neg) ? pos - neg : '0;
        m2_side_reg <= m1_side_reg;
        m3_s_reg    <= (s_short > PL_W'(ONE)) ? ONE : s_short[C:0];
        m3_side_reg <= m2_side_reg;
    end

    assign out_valid = m3_valid_reg;
    assign out_s     = m3_s_reg;
    assign out_side  = m3_side_reg;

endmodule

// ===== rtl/core/capsule_brush_coverage.sv =====
// Capsule brush coverage: top level with configuration registers and pipeline.
// Depends on cbc_pkg, cbc_div_pipe, cbc_sqrt_pipe and cbc_smooth.
//
// Usage: the feeder presents one pixel (pixel_x, pixel_y, old_coverage) and
// raises start; the beat is taken at every rising edge with start high and
// busy low. busy stays low, so a new pixel may enter on every cycle and the
// block sustains one pixel per clock.
// Each beat produces exactly one result beat: done is high for one cycle and
// new_coverage and write_enable are valid in that cycle. The receiver cannot
// stall the block, so results leave in the order pixels entered.
// The pipeline runs through three stages of dot products, a 32-stage
// divider for the projection, four stages for the nearest point and the
// squared distance, a square root with one stage per root bit, a divider
// with one stage per coverage bit, three smootherstep stages and the output
// register.
// The segment and brush are set through cfg_we, cfg_index and cfg_data while
// no pixel is in flight; writes to unknown indexes are dropped.
// Reset empties the pipeline and loads the default segment (a point at the
// origin), a 12 pixel radius and a hardness of 0.6.
module capsule_brush_coverage #(
    parameter int COORD_BITS    = 14,
    parameter int FRAC_BITS     = 8,
    parameter int COVERAGE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [COORD_BITS-1:0]        pixel_x,
    input  logic [COORD_BITS-1:0]        pixel_y,
    input  logic [COVERAGE_BITS:0]       old_coverage,
    output logic                         done,
    output logic [COVERAGE_BITS:0]       new_coverage,
    output logic                         write_enable,
    input  logic                         cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((COORD_BITS+FRAC_BITS+2) > (COVERAGE_BITS+1) ?
                   (COORD_BITS+FRAC_BITS+2) : (COVERAGE_BITS+1))-1:0] cfg_data
);
    import cbc_pkg::*;

    localparam int POS_W    = COORD_BITS + FRAC_BITS + 2;
    localparam int RADIUS_W = COORD_BITS + FRAC_BITS - 2;
    localparam int COV_W    = COVERAGE_BITS + 1;
    localparam int W_W      = POS_W + 1;
    localparam int PRD_W    = 2 * W_W;
    localparam int DOT_W    = 2 * W_W + 1;
    localparam int VV_W     = 2 * W_W - 1;
    localparam int P_W      = W_W + T_BITS;
    localparam int E_W      = POS_W + 3;
    localparam int M_W      = E_W - 1;
    localparam int SQ_W     = 2 * M_W;
    localparam int RAD_W    = 2 * E_W;
    localparam int SIDE1_W  = 2 + 2 * W_W + COV_W;
    localparam int SIDE3_W  = 2 + COV_W;
    localparam int LAT      = 11 + T_BITS + E_W + COVERAGE_BITS;

    localparam logic [COV_W-1:0]    ONE        = COV_W'(1) << COVERAGE_BITS;
    localparam logic [RADIUS_W-1:0] HALF_PIX   = RADIUS_W'(1) << (FRAC_BITS - 1);
    localparam logic [RADIUS_W-1:0] RST_RADIUS = RADIUS_W'(12) << FRAC_BITS;
    localparam longint ONE_L = longint'(1) << COVERAGE_BITS;
    localparam logic [COV_W-1:0]    RST_HARD   = COV_W'((ONE_L * 6 + 5) / 10);
    localparam logic [P_W-1:0]      T_HALF     = P_W'(1) << (T_BITS - 1);

    // Configuration registers.
    logic [POS_W-1:0]    start_x_reg;
    logic [POS_W-1:0]    start_y_reg;
    logic [POS_W-1:0]    end_x_reg;
    logic [POS_W-1:0]    end_y_reg;
    logic [RADIUS_W-1:0] brush_radius_reg;
    logic [COV_W-1:0]    brush_hardness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            end_x_reg          <= '0;
            end_y_reg          <= '0;
            brush_radius_reg   <= RST_RADIUS;
            brush_hardness_reg <= RST_HARD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:        start_x_reg        <= cfg_data[POS_W-1:0];
                REG_START_Y:        start_y_reg        <= cfg_data[POS_W-1:0];
                REG_END_X:          end_x_reg          <= cfg_data[POS_W-1:0];
                REG_END_Y:          end_y_reg          <= cfg_data[POS_W-1:0];
                REG_BRUSH_RADIUS:   brush_radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_BRUSH_HARDNESS: brush_hardness_reg <= cfg_data[COV_W-1:0];
                default:            ;
            endcase
        end
    end

    // Values derived from configuration, registered in cfg_prod_reg, then in
    // inner_reg and uden_reg. They settle long before a pixel needs them.
    logic [COV_W-1:0]          hard_sat;
    logic [RADIUS_W+COV_W-1:0] cfg_prod_reg;
    logic [RADIUS_W-1:0]       inner_pre;
    logic [RADIUS_W-1:0]       inner_next;
    logic [RADIUS_W-1:0]       inner_reg;
    logic [RADIUS_W-1:0]       uden_reg;

    assign hard_sat  = (brush_hardness_reg > ONE) ? ONE : brush_hardness_reg;
    assign inner_pre = cfg_prod_reg[RADIUS_W+COVERAGE_BITS-1:COVERAGE_BITS];

    always_comb
    begin
        if (brush_radius_reg <= HALF_PIX)
        begin
            inner_next = '0;
        end
        else if (inner_pre > brush_radius_reg - HALF_PIX)
        begin
            inner_next = brush_radius_reg - HALF_PIX;
        end
        else
        begin
            inner_next = inner_pre;
        end
    end

    always_ff @(posedge clk)
    begin
        cfg_prod_reg <= (RADIUS_W+COV_W)'(brush_radius_reg) * (RADIUS_W+COV_W)'(hard_sat);
        inner_reg    <= inner_next;
        uden_reg     <= brush_radius_reg - inner_next;
    end

    // Segment direction, stable while pixels are in flight.
    logic signed [W_W-1:0] vx;
    logic signed [W_W-1:0] vy;
    logic        [W_W-1:0] vx_mag;
    logic        [W_W-1:0] vy_mag;

    assign vx     = $signed({end_x_reg[POS_W-1], end_x_reg})
                  - $signed({start_x_reg[POS_W-1], start_x_reg});
    assign vy     = $signed({end_y_reg[POS_W-1], end_y_reg})
                  - $signed({start_y_reg[POS_W-1], start_y_reg});
    assign vx_mag = vx[W_W-1] ? W_W'(-vx) : W_W'(vx);
    assign vy_mag = vy[W_W-1] ? W_W'(-vy) : W_W'(vy);

    // The block never holds off the feeder.
    assign busy = 1'b0;

    // Stage 1: offset of the pixel centre from the segment start.
    logic                  s1_valid_reg;
    logic signed [W_W-1:0] s1_wx_reg;
    logic signed [W_W-1:0] s1_wy_reg;
    logic [COV_W-1:0]      s1_old_reg;

    // Stage 2: products for the dot product and the squared length.
    logic                    s2_valid_reg;
    logic signed [PRD_W-1:0] s2_vxx_reg;
    logic signed [PRD_W-1:0] s2_vyy_reg;
    logic signed [PRD_W-1:0] s2_dx_reg;
    logic signed [PRD_W-1:0] s2_dy_reg;
    logic signed [W_W-1:0]   s2_wx_reg;
    logic signed [W_W-1:0]   s2_wy_reg;
    logic [COV_W-1:0]        s2_old_reg;

    // Stage 3: sums.
    logic                    s3_valid_reg;
    logic [VV_W-1:0]         s3_vv_reg;
    logic signed [DOT_W-1:0] s3_dot_reg;
    logic signed [W_W-1:0]   s3_wx_reg;
    logic signed [W_W-1:0]   s3_wy_reg;
    logic [COV_W-1:0]        s3_old_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_wx_reg  <= $signed({3'b000, pixel_x, 1'b1, {(FRAC_BITS-1){1'b0}}})
                    - $signed({start_x_reg[POS_W-1], start_x_reg});
        s1_wy_reg  <= $signed({3'b000, pixel_y, 1'b1, {(FRAC_BITS-1){1'b0}}})
                    - $signed({start_y_reg[POS_W-1], start_y_reg});
        s1_old_reg <= (old_coverage > ONE) ? ONE : old_coverage;

        s2_vxx_reg <= vx * vx;
        s2_vyy_reg <= vy * vy;
        s2_dx_reg  <= s1_wx_reg * vx;
        s2_dy_reg  <= s1_wy_reg * vy;
        s2_wx_reg  <= s1_wx_reg;
        s2_wy_reg  <= s1_wy_reg;
        s2_old_reg <= s1_old_reg;

        s3_vv_reg  <= VV_W'(s2_vxx_reg + s2_vyy_reg);
        s3_dot_reg <= DOT_W'(s2_dx_reg) + DOT_W'(s2_dy_reg);
        s3_wx_reg  <= s2_wx_reg;
        s3_wy_reg  <= s2_wy_reg;
        s3_old_reg <= s2_old_reg;
    end

    // Classify the projection: before the start, past the end, or between.
    seg_mode_t       s3_mode;
    logic [VV_W-1:0] d1_num;

    always_comb
    begin
        if (s3_dot_reg[DOT_W-1] || (s3_dot_reg == '0))
        begin
            s3_mode = MODE_START;
        end
        else if (s3_dot_reg >= $signed(DOT_W'(s3_vv_reg)))
        begin
            s3_mode = MODE_END;
        end
        else
        begin
            s3_mode = MODE_MID;
        end
    end

    assign d1_num = (s3_mode == MODE_MID) ? s3_dot_reg[VV_W-1:0] : '0;

    // Projection parameter t = dot / |v|^2 in Q0.32.
    logic               d1_valid;
    logic [T_BITS-1:0]  d1_quot;
    logic [SIDE1_W-1:0] d1_side;

    cbc_div_pipe #(
        .DEN_W  (VV_W),
        .Q_W    (T_BITS),
        .SIDE_W (SIDE1_W)
    ) u_proj_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_num    (d1_num),
        .in_den    (s3_vv_reg),
        .in_side   ({s3_mode, s3_wx_reg, s3_wy_reg, s3_old_reg}),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    seg_mode_t             d1_mode;
    logic signed [W_W-1:0] d1_wx;
    logic signed [W_W-1:0] d1_wy;
    logic [COV_W-1:0]      d1_old;

    assign {d1_mode, d1_wx, d1_wy, d1_old} = d1_side;

    // Stage 4: t times each direction component.
    logic                  s4_valid_reg;
    logic [P_W-1:0]        s4_px_reg;
    logic [P_W-1:0]        s4_py_reg;
    seg_mode_t             s4_mode_reg;
    logic signed [W_W-1:0] s4_wx_reg;
    logic signed [W_W-1:0] s4_wy_reg;
    logic [COV_W-1:0]      s4_old_reg;

    // Stage 5: offset from the nearest point of the segment.
    logic                  s5_valid_reg;
    logic signed [E_W-1:0] s5_ex_reg;
    logic signed [E_W-1:0] s5_ey_reg;
    logic [COV_W-1:0]      s5_old_reg;

    // Stage 6 and 7: squared distance.
    logic                  s6_valid_reg;
    logic [SQ_W-1:0]       s6_sqx_reg;
    logic [SQ_W-1:0]       s6_sqy_reg;
    logic [COV_W-1:0]      s6_old_reg;
    logic                  s7_valid_reg;
    logic [RAD_W-1:0]      s7_sum_reg;
    logic [COV_W-1:0]      s7_old_reg;

    logic [P_W-1:0]        rnd_x;
    logic [P_W-1:0]        rnd_y;
    logic signed [E_W-1:0] tvx;
    logic signed [E_W-1:0] tvy;
    logic signed [E_W-1:0] ex_next;
    logic signed [E_W-1:0] ey_next;
    logic [M_W-1:0]        ex_mag;
    logic [M_W-1:0]        ey_mag;

    // Round half away from zero: round the magnitude, then restore the sign.
    assign rnd_x = s4_px_reg + T_HALF;
    assign rnd_y = s4_py_reg + T_HALF;
    assign tvx   = vx[W_W-1] ? -$signed({2'b00, rnd_x[P_W-1:T_BITS]})
                             :  $signed({2'b00, rnd_x[P_W-1:T_BITS]});
    assign tvy   = vy[W_W-1] ? -$signed({2'b00, rnd_y[P_W-1:T_BITS]})
                             :  $signed({2'b00, rnd_y[P_W-1:T_BITS]});

    always_comb
    begin
        case (s4_mode_reg)
            MODE_MID:
            begin
                ex_next = E_W'(s4_wx_reg) - tvx;
                ey_next = E_W'(s4_wy_reg) - tvy;
            end
            MODE_END:
            begin
                ex_next = E_W'(s4_wx_reg) - E_W'(vx);
                ey_next = E_W'(s4_wy_reg) - E_W'(vy);
            end
            default:
            begin
                ex_next = E_W'(s4_wx_reg);
                ey_next = E_W'(s4_wy_reg);
            end
        endcase
    end

    assign ex_mag = s5_ex_reg[E_W-1] ? M_W'(-s5_ex_reg) : M_W'(s5_ex_reg);
    assign ey_mag = s5_ey_reg[E_W-1] ? M_W'(-s5_ey_reg) : M_W'(s5_ey_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= d1_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_px_reg   <= P_W'(vx_mag) * P_W'(d1_quot);
        s4_py_reg   <= P_W'(vy_mag) * P_W'(d1_quot);
        s4_mode_reg <= d1_mode;
        s4_wx_reg   <= d1_wx;
        s4_wy_reg   <= d1_wy;
        s4_old_reg  <= d1_old;

        s5_ex_reg   <= ex_next;
        s5_ey_reg   <= ey_next;
        s5_old_reg  <= s4_old_reg;

        s6_sqx_reg  <= SQ_W'(ex_mag) * SQ_W'(ex_mag);
        s6_sqy_reg  <= SQ_W'(ey_mag) * SQ_W'(ey_mag);
        s6_old_reg  <= s5_old_reg;

        s7_sum_reg  <= RAD_W'(s6_sqx_reg) + RAD_W'(s6_sqy_reg);
        s7_old_reg  <= s6_old_reg;
    end

    // Distance to the segment, floor of the square root, in Q.F.
    logic             sq_valid;
    logic [E_W-1:0]   sq_root;
    logic [COV_W-1:0] sq_old;

    cbc_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .SIDE_W (COV_W)
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s7_valid_reg),
        .in_rad    (s7_sum_reg),
        .in_side   (s7_old_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_old)
    );

    // Outside the rim (or zero radius) gives nothing; inside the core gives
    // full coverage. Only the rim has a nonzero falloff divider numerator.
    logic                sq_far;
    logic                sq_core;
    logic [RADIUS_W-1:0] d2_num;

    assign sq_far  = (brush_radius_reg == '0) || (sq_root >= E_W'(brush_radius_reg));
    assign sq_core = sq_root <= E_W'(inner_reg);
    assign d2_num  = (sq_far || sq_core) ? '0
                   : brush_radius_reg - sq_root[RADIUS_W-1:0];

    logic                     d2_valid;
    logic [COVERAGE_BITS-1:0] d2_quot;
    logic [SIDE3_W-1:0]       d2_side;

    cbc_div_pipe #(
        .DEN_W  (RADIUS_W),
        .Q_W    (COVERAGE_BITS),
        .SIDE_W (SIDE3_W)
    ) u_rim_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    (d2_num),
        .in_den    (uden_reg),
        .in_side   ({sq_far, sq_core, sq_old}),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_side  (d2_side)
    );

    logic               sm_valid;
    logic [COV_W-1:0]   sm_s;
    logic [SIDE3_W-1:0] sm_side;

    cbc_smooth #(
        .COVERAGE_BITS (COVERAGE_BITS),
        .SIDE_W        (SIDE3_W)
    ) u_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_u      (d2_quot),
        .in_side   (d2_side),
        .out_valid (sm_valid),
        .out_s     (sm_s),
        .out_side  (sm_side)
    );

    // Max-combine with the stored coverage and register the result beat.
    logic             sm_far;
    logic             sm_core;
    logic [COV_W-1:0] sm_old;
    logic [COV_W-1:0] seg_cov;
    logic             improve;
    logic             done_reg;
    logic [COV_W-1:0] new_cov_reg;
    logic             we_reg;

    assign {sm_far, sm_core, sm_old} = sm_side;
    assign seg_cov = sm_far ? '0 : (sm_core ? ONE : sm_s);
    assign improve = seg_cov > sm_old;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        new_cov_reg <= improve ? seg_cov : sm_old;
        we_reg      <= improve;
    end

    assign done         = done_reg;
    assign new_coverage = new_cov_reg;
    assign write_enable = we_reg;

    // Every accepted pixel comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result beat missing after pipeline latency");

    // A result beat never comes out without a pixel that entered.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result beat without an accepted pixel");

    // Coverage stays within one, and a write always carries nonzero coverage.
    a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (new_coverage <= ONE) && (!write_enable || (new_coverage != '0)))
        else $error("coverage out of range");

endmodule
